>>> hw/rtl/amc_pkg.sv
// Shared types and constants of the multi-pattern string matcher.
package amc_pkg;

  localparam int unsigned PAT_W  = 5;
  localparam int unsigned TAG_W  = 6;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PATS   = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NODEFULL = 2'd1;
  localparam logic [1:0] ST_PATFULL  = 2'd2;
  localparam logic [1:0] ST_NOBUILD  = 2'd3;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] symbol;
    logic       final_req;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [PAT_W-1:0] pattern_id;
    logic [CNT_W-1:0] hits;
    logic [1:0]       status;
    logic             run_end;
  } out_t;

endpackage

>>> hw/rtl/amc_count.sv
// Bank of saturating per-pattern occurrence counters.
module amc_count (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     inc,
  input  logic [amc_pkg::PAT_W-1:0] inc_idx,
  input  logic [amc_pkg::PAT_W-1:0] rd_idx,
  output logic [amc_pkg::CNT_W-1:0] rd_cnt
);
  import amc_pkg::*;

  logic [CNT_W-1:0] cnt_r [PATS];

  // Clear all counters, or bump one unless it is already at its maximum.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < PATS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (inc && (cnt_r[inc_idx] != {CNT_W{1'b1}})) begin
      cnt_r[inc_idx] <= cnt_r[inc_idx] + 1'b1;
    end
  end

  assign rd_cnt = cnt_r[rd_idx];

endmodule

>>> hw/rtl/multi_pattern_string_matcher.sv
// Aho-Corasick matcher: trie insert, breadth-first link build, text scan and count clear.
//
//  channel  ports                       transfer when
//  input    start, busy, in_data         start high and busy low
//  result   out_valid, out_data          out_valid high (one cycle, no stall)
//
// Every step is one registered read of the node tables under one sequencer.
// A pattern byte walks the sibling chain of the current node and adds a new
// node if no child matches; a final byte also tags the node. A text byte
// walks sibling chains and failure links, counts each output-link match, and
// on a final byte reports each pattern's count. A build links nodes breadth-first.
// Reset is synchronous; the trie tables need no clearing, only the root entry.
module multi_pattern_string_matcher (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  amc_pkg::in_t  in_data,
  output logic          out_valid,
  output amc_pkg::out_t out_data
);
  import amc_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FCA   = 5'd1;
  localparam logic [4:0] S_FCB   = 5'd2;
  localparam logic [4:0] S_FCC   = 5'd3;
  localparam logic [4:0] S_IR    = 5'd4;
  localparam logic [4:0] S_INEW  = 5'd5;
  localparam logic [4:0] S_ITAG  = 5'd6;
  localparam logic [4:0] S_ITAGD = 5'd7;
  localparam logic [4:0] S_BDEQ  = 5'd8;
  localparam logic [4:0] S_BU    = 5'd9;
  localparam logic [4:0] S_BV0   = 5'd10;
  localparam logic [4:0] S_BV1   = 5'd11;
  localparam logic [4:0] S_BG0   = 5'd12;
  localparam logic [4:0] S_BG2   = 5'd13;
  localparam logic [4:0] S_BSETF = 5'd14;
  localparam logic [4:0] S_BD    = 5'd15;
  localparam logic [4:0] S_SR    = 5'd16;
  localparam logic [4:0] S_SF    = 5'd17;
  localparam logic [4:0] S_ST    = 5'd18;
  localparam logic [4:0] S_ST1   = 5'd19;
  localparam logic [4:0] S_SH    = 5'd20;
  localparam logic [4:0] S_SEND  = 5'd21;
  localparam logic [4:0] S_SREP  = 5'd22;

  // Node tables.
  logic [7:0]        node_symbol  [256];
  logic [7:0]        next_sibling [256];
  logic [7:0]        first_child  [256];
  logic [7:0]        fail_node    [256];
  logic [7:0]        dict_link    [256];
  logic [TAG_W-1:0]  word_tag     [256];
  logic [7:0]        bfs_queue    [256];

  logic [7:0]       sym_q, nsib_q, fc_q, fail_q, dict_q, q_q;
  logic [TAG_W-1:0] tag_q;
  logic [7:0]       ra, ra_q;
  logic [7:0]       fc_rd, fail_rd, dict_rd;
  logic [TAG_W-1:0] tag_rd;

  logic             sym_we, nsib_we, fc_we, fail_we, dict_we, tag_we, q_we;
  logic [7:0]       sym_wa, nsib_wa, fc_wa, fail_wa, dict_wa, tag_wa, q_wa;
  logic [7:0]       sym_wd, nsib_wd, fc_wd, fail_wd, dict_wd, q_wd;
  logic [TAG_W-1:0] tag_wd;

  // Control and working registers.
  logic [4:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic [7:0]       sym_r, sym_nxt;
  logic             fin_r, fin_nxt;
  logic [7:0]       ins_cur_r, ins_cur_nxt, scan_cur_r, scan_cur_nxt;
  logic [8:0]       nodes_r, nodes_nxt;
  logic [TAG_W-1:0] pats_r, pats_nxt;
  logic             links_r, links_nxt, drop_r, drop_nxt;
  logic [7:0]       root_fc_r;
  logic [7:0]       fcu_r, fcu_nxt, fcc_r, fcc_nxt, fcv_r, fcv_nxt;
  logic [7:0]       res_r, res_nxt, head_r, head_nxt;
  logic [7:0]       u_r, u_nxt, v_r, v_nxt, nxt_r, nxt_nxt, f_r, f_nxt;
  logic [8:0]       qh_r, qh_nxt, qt_r, qt_nxt;
  logic [PAT_W-1:0] rp_r, rp_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic             cnt_clr, cnt_inc;
  logic [PAT_W-1:0] cnt_idx;
  logic [CNT_W-1:0] cnt_rd;
  logic [7:0]       tval;
  logic [TAG_W-1:0] tag_m1;

  amc_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cnt_clr),
    .inc     (cnt_inc),
    .inc_idx (cnt_idx),
    .rd_idx  (rp_r),
    .rd_cnt  (cnt_rd)
  );

  // Table writes and registered reads: node tables at the shared address, the queue at its head.
  always_ff @(posedge clk) begin
    if (sym_we)  node_symbol[sym_wa]   <= sym_wd;
    if (nsib_we) next_sibling[nsib_wa] <= nsib_wd;
    if (fc_we)   first_child[fc_wa]    <= fc_wd;
    if (fail_we) fail_node[fail_wa]    <= fail_wd;
    if (dict_we) dict_link[dict_wa]    <= dict_wd;
    if (tag_we)  word_tag[tag_wa]      <= tag_wd;
    if (q_we)    bfs_queue[q_wa]       <= q_wd;
    sym_q  <= node_symbol[ra];
    nsib_q <= next_sibling[ra];
    fc_q   <= first_child[ra];
    fail_q <= fail_node[ra];
    dict_q <= dict_link[ra];
    tag_q  <= word_tag[ra];
    q_q    <= bfs_queue[qh_r[7:0]];
    ra_q   <= ra;
  end

  // The root entry reads as its reset value: no tag, no links.
  assign fc_rd   = (ra_q == 8'd0) ? root_fc_r : fc_q;
  assign fail_rd = (ra_q == 8'd0) ? 8'd0 : fail_q;
  assign dict_rd = (ra_q == 8'd0) ? 8'd0 : dict_q;
  assign tag_rd  = (ra_q == 8'd0) ? '0 : tag_q;
  assign tag_m1  = tag_rd - 6'd1;
  assign tval    = (tag_rd != '0) ? u_r : dict_rd;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  sym_nxt = sym_r;  fin_nxt = fin_r;
    ins_cur_nxt = ins_cur_r;  scan_cur_nxt = scan_cur_r;  nodes_nxt = nodes_r;
    pats_nxt = pats_r;  links_nxt = links_r;  drop_nxt = drop_r;
    fcu_nxt = fcu_r;  fcc_nxt = fcc_r;  fcv_nxt = fcv_r;  res_nxt = res_r;
    head_nxt = head_r;  u_nxt = u_r;  v_nxt = v_r;  nxt_nxt = nxt_r;  f_nxt = f_r;
    qh_nxt = qh_r;  qt_nxt = qt_r;  rp_nxt = rp_r;
    out_valid_nxt = 1'b0;  out_data_nxt = '0;
    ra = 8'd0;
    sym_we = 1'b0;  sym_wa = v_r;  sym_wd = sym_r;
    nsib_we = 1'b0; nsib_wa = v_r; nsib_wd = head_r;
    fc_we = 1'b0;   fc_wa = v_r;   fc_wd = 8'd0;
    fail_we = 1'b0; fail_wa = v_r; fail_wd = f_r;
    dict_we = 1'b0; dict_wa = v_r; dict_wd = (tag_rd != '0) ? f_r : dict_rd;
    tag_we = 1'b0;  tag_wa = v_r;  tag_wd = '0;
    q_we = 1'b0;    q_wa = qt_r[7:0]; q_wd = v_r;
    cnt_clr = 1'b0; cnt_inc = 1'b0; cnt_idx = tag_m1[PAT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          sym_nxt = in_data.symbol;
          fin_nxt = in_data.final_req;
          fcc_nxt = in_data.symbol;
          unique case (in_data.cmd)
            CMD_ADD: begin
              if (drop_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status  = ST_NODEFULL;
                out_data_nxt.run_end = 1'b1;
                if (in_data.final_req) begin
                  drop_nxt = 1'b0;
                  ins_cur_nxt = 8'd0;
                end
              end else begin
                fcu_nxt = ins_cur_r;
                ret_nxt = S_IR;
                state_nxt = S_FCA;
              end
            end
            CMD_BUILD: begin
              q_we = 1'b1;  q_wa = 8'd0;  q_wd = 8'd0;
              qh_nxt = 9'd0;  qt_nxt = 9'd1;
              state_nxt = S_BDEQ;
            end
            CMD_SCAN: begin
              if (!links_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status  = ST_NOBUILD;
                out_data_nxt.run_end = 1'b1;
              end else begin
                u_nxt = scan_cur_r;
                fcu_nxt = scan_cur_r;
                ret_nxt = S_SR;
                state_nxt = S_FCA;
              end
            end
            default: begin
              cnt_clr = 1'b1;
              scan_cur_nxt = 8'd0;
              out_valid_nxt = 1'b1;
              out_data_nxt.run_end = 1'b1;
            end
          endcase
        end
      end
      // Child search along the sibling chain of fcu_r for symbol fcc_r.
      S_FCA: begin
        ra = fcu_r;
        state_nxt = S_FCB;
      end
      S_FCB: begin
        head_nxt = fc_rd;
        if (fc_rd == 8'd0) begin
          res_nxt = 8'd0;
          state_nxt = ret_r;
        end else begin
          fcv_nxt = fc_rd;
          ra = fc_rd;
          state_nxt = S_FCC;
        end
      end
      S_FCC: begin
        if (sym_q == fcc_r) begin
          res_nxt = fcv_r;
          state_nxt = ret_r;
        end else if (nsib_q == 8'd0) begin
          res_nxt = 8'd0;
          state_nxt = ret_r;
        end else begin
          fcv_nxt = nsib_q;
          ra = nsib_q;
        end
      end
      // Pattern insert.
      S_IR: begin
        if (res_r != 8'd0) begin
          ins_cur_nxt = res_r;
          if (fin_r) begin
            state_nxt = S_ITAG;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt.run_end = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!nodes_r[8]) begin
          sym_we = 1'b1;  sym_wa = nodes_r[7:0];
          nsib_we = 1'b1; nsib_wa = nodes_r[7:0];
          fc_we = 1'b1;   fc_wa = nodes_r[7:0];
          tag_we = 1'b1;  tag_wa = nodes_r[7:0];
          v_nxt = nodes_r[7:0];
          nodes_nxt = nodes_r + 9'd1;
          links_nxt = 1'b0;
          state_nxt = S_INEW;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status  = ST_NODEFULL;
          out_data_nxt.run_end = 1'b1;
          drop_nxt = !fin_r;
          if (fin_r) ins_cur_nxt = 8'd0;
          state_nxt = S_IDLE;
        end
      end
      S_INEW: begin
        fc_we = 1'b1;  fc_wa = ins_cur_r;  fc_wd = v_r;
        ins_cur_nxt = v_r;
        if (fin_r) begin
          state_nxt = S_ITAG;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.run_end = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ITAG: begin
        ra = ins_cur_r;
        state_nxt = S_ITAGD;
      end
      S_ITAGD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.run_end = 1'b1;
        if (tag_rd != '0) begin
          out_data_nxt.pattern_id = tag_m1[PAT_W-1:0];
        end else if (!pats_r[PAT_W]) begin
          out_data_nxt.pattern_id = pats_r[PAT_W-1:0];
          tag_we = 1'b1;  tag_wa = ins_cur_r;  tag_wd = pats_r + 6'd1;
          pats_nxt = pats_r + 6'd1;
          links_nxt = 1'b0;
        end else begin
          out_data_nxt.status = ST_PATFULL;
        end
        ins_cur_nxt = 8'd0;
        state_nxt = S_IDLE;
      end
      // Breadth-first link build.
      S_BDEQ: begin
        if (qh_r == qt_r) begin
          links_nxt = 1'b1;
          scan_cur_nxt = 8'd0;
          out_valid_nxt = 1'b1;
          out_data_nxt.run_end = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          qh_nxt = qh_r + 9'd1;
          state_nxt = S_BU;
        end
      end
      S_BU: begin
        u_nxt = q_q;
        ra = q_q;
        state_nxt = S_BV0;
      end
      S_BV0: begin
        if (fc_rd == 8'd0) begin
          state_nxt = S_BDEQ;
        end else begin
          v_nxt = fc_rd;
          ra = fc_rd;
          state_nxt = S_BV1;
        end
      end
      S_BV1: begin
        fcc_nxt = sym_q;
        nxt_nxt = nsib_q;
        if (u_r == 8'd0) begin
          f_nxt = 8'd0;
          state_nxt = S_BSETF;
        end else begin
          ra = u_r;
          state_nxt = S_BG0;
        end
      end
      S_BG0: begin
        fcu_nxt = fail_rd;
        ret_nxt = S_BG2;
        state_nxt = S_FCA;
      end
      S_BG2: begin
        if (res_r != 8'd0) begin
          f_nxt = (res_r == v_r) ? 8'd0 : res_r;
          state_nxt = S_BSETF;
        end else if (fcu_r == 8'd0) begin
          f_nxt = 8'd0;
          state_nxt = S_BSETF;
        end else begin
          ra = fcu_r;
          state_nxt = S_BG0;
        end
      end
      S_BSETF: begin
        fail_we = 1'b1;
        ra = f_r;
        state_nxt = S_BD;
      end
      S_BD: begin
        dict_we = 1'b1;
        if (!qt_r[8]) begin
          q_we = 1'b1;
          qt_nxt = qt_r + 9'd1;
        end
        if (nxt_r == 8'd0) begin
          state_nxt = S_BDEQ;
        end else begin
          v_nxt = nxt_r;
          ra = nxt_r;
          state_nxt = S_BV1;
        end
      end
      // Text scan: failure walk, then output-link walk.
      S_SR: begin
        if (res_r != 8'd0) begin
          u_nxt = res_r;
          state_nxt = S_ST;
        end else if (u_r == 8'd0) begin
          state_nxt = S_ST;
        end else begin
          ra = u_r;
          state_nxt = S_SF;
        end
      end
      S_SF: begin
        u_nxt = fail_rd;
        fcu_nxt = fail_rd;
        ret_nxt = S_SR;
        state_nxt = S_FCA;
      end
      S_ST: begin
        scan_cur_nxt = u_r;
        ra = u_r;
        state_nxt = S_ST1;
      end
      S_ST1: begin
        if (tval == 8'd0) begin
          state_nxt = S_SEND;
        end else begin
          ra = tval;
          state_nxt = S_SH;
        end
      end
      S_SH: begin
        cnt_inc = 1'b1;
        if (dict_rd == 8'd0) begin
          state_nxt = S_SEND;
        end else begin
          ra = dict_rd;
        end
      end
      S_SEND: begin
        if (fin_r && (pats_r != '0)) begin
          rp_nxt = '0;
          state_nxt = S_SREP;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.run_end = 1'b1;
          if (fin_r) begin
            cnt_clr = 1'b1;
            scan_cur_nxt = 8'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SREP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.kind = KIND_REPORT;
        out_data_nxt.pattern_id = rp_r;
        out_data_nxt.hits = cnt_rd;
        if (({1'b0, rp_r} + 6'd1) == pats_r) begin
          out_data_nxt.run_end = 1'b1;
          cnt_clr = 1'b1;
          scan_cur_nxt = 8'd0;
          state_nxt = S_IDLE;
        end else begin
          rp_nxt = rp_r + 5'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;      ins_cur_r <= 8'd0;   scan_cur_r <= 8'd0;
      nodes_r <= 9'd1;        pats_r <= '0;        links_r <= 1'b1;
      drop_r <= 1'b0;         root_fc_r <= 8'd0;   out_valid_r <= 1'b0;
      ret_r <= S_IDLE;        qh_r <= 9'd0;        qt_r <= 9'd0;
    end else begin
      state_r <= state_nxt;   ins_cur_r <= ins_cur_nxt; scan_cur_r <= scan_cur_nxt;
      nodes_r <= nodes_nxt;   pats_r <= pats_nxt;  links_r <= links_nxt;
      drop_r <= drop_nxt;     out_valid_r <= out_valid_nxt;
      ret_r <= ret_nxt;       qh_r <= qh_nxt;      qt_r <= qt_nxt;
      if (fc_we && (fc_wa == 8'd0)) root_fc_r <= fc_wd;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;  fin_r <= fin_nxt;  fcu_r <= fcu_nxt;  fcc_r <= fcc_nxt;
    fcv_r <= fcv_nxt;  res_r <= res_nxt;  head_r <= head_nxt;
    u_r <= u_nxt;  v_r <= v_nxt;  nxt_r <= nxt_nxt;  f_r <= f_nxt;
    rp_r <= rp_nxt;  out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_report_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind) |-> ($past(state_r) == S_SREP))
    else $error("count report outside the report phase");
  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_r != 9'd0) && (nodes_r <= 9'd256))
    else $error("node count out of range");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BU) |-> (qh_r <= qt_r))
    else $error("queue head passed tail");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> !(out_valid_r && $past(state_r) == S_IDLE))
    else $error("result issued from idle while busy");
`endif

endmodule
